// ===== rtl/core/mecanum_wheel_mixer_macros.svh =====
// Assertion macros shared by the mecanum wheel mixer modules
`ifndef MECANUM_WHEEL_MIXER_MACROS_SVH
`define MECANUM_WHEEL_MIXER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MWM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mwm assertion failed");

// next-cycle implication, disabled during reset
`define MWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mwm assertion failed");

`endif

// ===== rtl/core/mwm_pkg.sv =====
// Shared constants and types of the mecanum wheel mixer
package mwm_pkg;
    localparam int NUM_WHEELS = 4;
    localparam int SPEED_W    = 16;
    localparam int SUM_W      = SPEED_W + 2;
    localparam int MAG_W      = SUM_W - 1;
    localparam int LIM_W      = 15;
    localparam int PROD_W     = MAG_W + LIM_W;
    localparam int QUO_W      = LIM_W;
    localparam int NUM_CELLS  = QUO_W;

    localparam logic [LIM_W-1:0] LIMIT_RESET = {LIM_W{1'b1}};

    typedef struct packed {
        logic [NUM_WHEELS-1:0][MAG_W-1:0] rem;
        logic [NUM_WHEELS-1:0][QUO_W-1:0] num;
        logic [NUM_WHEELS-1:0][QUO_W-1:0] quo;
        logic [NUM_WHEELS-1:0][QUO_W-1:0] pass;
        logic [NUM_WHEELS-1:0]            neg;
        logic [MAG_W-1:0]                 div;
        logic                             scale;
    } t_div_beat;
endpackage

// ===== rtl/core/mwm_cmd_if.sv =====
// Chassis command channel: valid/ready plus the three chassis speeds
interface mwm_cmd_if;
    import mwm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_sideways;
    logic signed [SPEED_W-1:0] speed_forward;
    logic signed [SPEED_W-1:0] speed_rotate;

    modport source (
        output valid, speed_sideways, speed_forward, speed_rotate,
        input  ready
    );
    modport sink (
        input  valid, speed_sideways, speed_forward, speed_rotate,
        output ready
    );
endinterface

// ===== rtl/core/mwm_whl_if.sv =====
// Wheel speed channel: valid/ready plus four wheel speeds and the scale flag
interface mwm_whl_if;
    import mwm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] wheel_front_a;
    logic signed [SPEED_W-1:0] wheel_front_b;
    logic signed [SPEED_W-1:0] wheel_rear_a;
    logic signed [SPEED_W-1:0] wheel_rear_b;
    logic                      was_scaled;

    modport source (
        output valid, wheel_front_a, wheel_front_b, wheel_rear_a, wheel_rear_b, was_scaled,
        input  ready
    );
    modport sink (
        input  valid, wheel_front_a, wheel_front_b, wheel_rear_a, wheel_rear_b, was_scaled,
        output ready
    );
endinterface

// ===== rtl/core/mwm_mix.sv =====
// Front stages: wheel mixing, magnitude and peak search, scaling product
`include "mecanum_wheel_mixer_macros.svh"

module mwm_mix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [mwm_pkg::SPEED_W-1:0]  i_sx,
    input  logic signed [mwm_pkg::SPEED_W-1:0]  i_fy,
    input  logic signed [mwm_pkg::SPEED_W-1:0]  i_rz,
    input  logic        [mwm_pkg::LIM_W-1:0]    i_limit,
    output logic                                o_valid,
    input  logic                                i_ready,
    output mwm_pkg::t_div_beat                  o_beat
);
    import mwm_pkg::*;

    logic                    rdy_a, rdy_b, rdy_c;

    logic                    r_va;
    logic signed [SUM_W-1:0] r_sum [NUM_WHEELS];
    logic [LIM_W-1:0]        r_lim_a;

    logic                    r_vb;
    logic [MAG_W-1:0]        r_mag [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   r_neg;
    logic [MAG_W-1:0]        r_peak;
    logic                    r_scale;
    logic [LIM_W-1:0]        r_lim_b;

    logic                    r_vc;
    t_div_beat               r_beat;

    logic signed [SUM_W-1:0] sx_e, fy_e, rz_e;
    logic signed [SUM_W-1:0] n_sum [NUM_WHEELS];
    logic [SUM_W-1:0]        abs_v [NUM_WHEELS];
    logic [MAG_W-1:0]        n_mag [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   n_neg;
    logic [MAG_W-1:0]        p01, p23, n_peak;
    logic                    n_scale;
    logic [PROD_W-1:0]       prod [NUM_WHEELS];
    t_div_beat               n_beat;

    assign rdy_c   = !r_vc || i_ready;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vc;
    assign o_beat  = r_beat;

    always_comb begin
        sx_e = {{(SUM_W-SPEED_W){i_sx[SPEED_W-1]}}, i_sx};
        fy_e = {{(SUM_W-SPEED_W){i_fy[SPEED_W-1]}}, i_fy};
        rz_e = {{(SUM_W-SPEED_W){i_rz[SPEED_W-1]}}, i_rz};
        n_sum[0] = rz_e + sx_e - fy_e;
        n_sum[1] = rz_e + sx_e + fy_e;
        n_sum[2] = rz_e - sx_e + fy_e;
        n_sum[3] = rz_e - sx_e - fy_e;
    end

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            n_neg[k] = r_sum[k][SUM_W-1];
            abs_v[k] = n_neg[k] ? SUM_W'(-r_sum[k]) : SUM_W'(r_sum[k]);
            n_mag[k] = abs_v[k][MAG_W-1:0];
        end
        p01     = (n_mag[0] > n_mag[1]) ? n_mag[0] : n_mag[1];
        p23     = (n_mag[2] > n_mag[3]) ? n_mag[2] : n_mag[3];
        n_peak  = (p01 > p23) ? p01 : p23;
        n_scale = {{(MAG_W-LIM_W){1'b0}}, r_lim_a} < n_peak;
    end

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            prod[k]        = PROD_W'(r_mag[k]) * PROD_W'(r_lim_b);
            n_beat.rem[k]  = prod[k][PROD_W-1:QUO_W];
            n_beat.num[k]  = prod[k][QUO_W-1:0];
            n_beat.quo[k]  = '0;
            n_beat.pass[k] = r_mag[k][QUO_W-1:0];
        end
        n_beat.neg   = r_neg;
        n_beat.div   = r_peak;
        n_beat.scale = r_scale;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (rdy_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_sum   <= n_sum;
            r_lim_a <= i_limit;
        end
        if (rdy_b && r_va) begin
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_peak  <= n_peak;
            r_scale <= n_scale;
            r_lim_b <= r_lim_a;
        end
        if (rdy_c && r_vb) begin
            r_beat <= n_beat;
        end
    end

    `MWM_ASSERT_IMPL(a_peak_bounds, i_clk, i_rst_n, r_vb,
        r_mag[0] <= r_peak && r_mag[1] <= r_peak && r_mag[2] <= r_peak && r_mag[3] <= r_peak)
    `MWM_ASSERT_IMPL(a_scale_nonzero, i_clk, i_rst_n, r_vb && r_scale,
        r_peak != '0 && {{(MAG_W-LIM_W){1'b0}}, r_lim_b} < r_peak)
endmodule

// ===== rtl/core/mwm_div_cell.sv =====
// Divider cell: one restoring quotient bit for all four wheels per stage
`include "mecanum_wheel_mixer_macros.svh"

module mwm_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mwm_pkg::t_div_beat i_beat,
    output logic               o_valid,
    input  logic               i_ready,
    output mwm_pkg::t_div_beat o_beat
);
    import mwm_pkg::*;

    logic             r_valid;
    t_div_beat        r_beat;
    t_div_beat        n_beat;
    logic [MAG_W:0]   trial [NUM_WHEELS];
    logic [MAG_W:0]   diff  [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] ge;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_comb begin
        n_beat = i_beat;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            trial[k] = {i_beat.rem[k], i_beat.num[k][QUO_W-1]};
            diff[k]  = trial[k] - {1'b0, i_beat.div};
            ge[k]    = trial[k] >= {1'b0, i_beat.div};
            n_beat.rem[k] = ge[k] ? diff[k][MAG_W-1:0] : trial[k][MAG_W-1:0];
            n_beat.num[k] = {i_beat.num[k][QUO_W-2:0], 1'b0};
            n_beat.quo[k] = {i_beat.quo[k][QUO_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    `MWM_ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_valid && r_beat.scale,
        r_beat.rem[0] < r_beat.div && r_beat.rem[1] < r_beat.div &&
        r_beat.rem[2] < r_beat.div && r_beat.rem[3] < r_beat.div)
endmodule

// ===== rtl/core/mecanum_wheel_mixer.sv =====
// Mecanum wheel mixer top level: mixing front end, divider cell row, output register
//
//   channel   dir  handshake      payload
//   i_cmd     in   valid/ready    speed_sideways, speed_forward, speed_rotate
//   o_whl     out  valid/ready    wheel_front_a/b, wheel_rear_a/b, was_scaled
//   i_cfg_*   in   write enable   wheel_speed_limit (15 bits)
//
// One command per cycle while the output is not stalled; 3 front stages, 15 divider cells, output.
// Every stage advances when its successor is empty or moving, so bubbles collapse.
// Reset is synchronous and clears only the valid bits and the limit (to 32767).
// A stalled output holds its beat while earlier stages keep filling.

module mecanum_wheel_mixer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mwm_cmd_if.sink                     i_cmd,
    mwm_whl_if.source                   o_whl,
    input  logic                        i_cfg_wr_en,
    input  logic [mwm_pkg::LIM_W-1:0]   i_cfg_wr_data
);
    import mwm_pkg::*;

    logic [LIM_W-1:0]          r_limit;

    logic                      c_valid [NUM_CELLS+1];
    logic                      c_ready [NUM_CELLS+1];
    t_div_beat                 c_beat  [NUM_CELLS+1];

    logic                      en_out;
    logic                      r_out_valid;
    logic signed [SPEED_W-1:0] r_wheel [NUM_WHEELS];
    logic                      r_scaled;
    logic signed [SPEED_W-1:0] n_wheel [NUM_WHEELS];
    logic [QUO_W-1:0]          res [NUM_WHEELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    mwm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .o_ready (i_cmd.ready),
        .i_sx    (i_cmd.speed_sideways),
        .i_fy    (i_cmd.speed_forward),
        .i_rz    (i_cmd.speed_rotate),
        .i_limit (r_limit),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_beat  (c_beat[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        mwm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_beat  (c_beat[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_beat  (c_beat[g+1])
        );
    end

    assign en_out             = !r_out_valid || o_whl.ready;
    assign c_ready[NUM_CELLS] = en_out;

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            res[k] = c_beat[NUM_CELLS].scale ? c_beat[NUM_CELLS].quo[k]
                                             : c_beat[NUM_CELLS].pass[k];
            n_wheel[k] = c_beat[NUM_CELLS].neg[k] ? SPEED_W'(-{1'b0, res[k]})
                                                  : SPEED_W'({1'b0, res[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= c_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && c_valid[NUM_CELLS]) begin
            r_wheel  <= n_wheel;
            r_scaled <= c_beat[NUM_CELLS].scale;
        end
    end

    assign o_whl.valid         = r_out_valid;
    assign o_whl.wheel_front_a = r_wheel[0];
    assign o_whl.wheel_front_b = r_wheel[1];
    assign o_whl.wheel_rear_a  = r_wheel[2];
    assign o_whl.wheel_rear_b  = r_wheel[3];
    assign o_whl.was_scaled    = r_scaled;
endmodule

// ===== tb/mecanum_wheel_mixer_tb.sv =====
// Self-checking testbench for the mecanum wheel mixer: mixing, desaturation, limit writes
`timescale 1ns / 1ps

module mecanum_wheel_mixer_tb;
    import mwm_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;
    localparam int PHASE_ITEMS    = 150;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic signed [SPEED_W-1:0] sideways;
        logic signed [SPEED_W-1:0] forward;
        logic signed [SPEED_W-1:0] rotate;
    } t_chassis_cmd;

    typedef struct packed {
        logic signed [SPEED_W-1:0] front_a;
        logic signed [SPEED_W-1:0] front_b;
        logic signed [SPEED_W-1:0] rear_a;
        logic signed [SPEED_W-1:0] rear_b;
        logic                      scaled;
    } t_wheel_set;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [LIM_W-1:0] i_cfg_wr_data;

    mwm_cmd_if cmd_bus ();
    mwm_whl_if whl_bus ();

    mecanum_wheel_mixer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_bus),
        .o_whl         (whl_bus),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    t_chassis_cmd     cmd_pending[$];
    t_wheel_set       wheel_expect[$];
    logic [LIM_W-1:0] limit_model;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               cmd_queued;
    int               cmd_accepted;
    int               wheels_checked;
    int               scaled_seen;
    int               limit_writes;
    int               mismatches;
    int               idle_cycles;
    bit               cmd_taken;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_wheel_set mix_and_desaturate(t_chassis_cmd c, logic [LIM_W-1:0] lim);
        longint     w[NUM_WHEELS];
        longint     peak;
        longint     mag;
        longint     lim_l;
        t_wheel_set r;
        lim_l = lim;
        w[0] = longint'(c.rotate) + longint'(c.sideways) - longint'(c.forward);
        w[1] = longint'(c.rotate) + longint'(c.sideways) + longint'(c.forward);
        w[2] = longint'(c.rotate) - longint'(c.sideways) + longint'(c.forward);
        w[3] = longint'(c.rotate) - longint'(c.sideways) - longint'(c.forward);
        peak = 0;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            mag = (w[k] < 0) ? -w[k] : w[k];
            if (mag > peak) peak = mag;
        end
        r.scaled = (lim_l < peak);
        if (r.scaled) begin
            for (int k = 0; k < NUM_WHEELS; k++) w[k] = (w[k] * lim_l) / peak;
        end
        r.front_a = w[0][SPEED_W-1:0];
        r.front_b = w[1][SPEED_W-1:0];
        r.rear_a  = w[2][SPEED_W-1:0];
        r.rear_b  = w[3][SPEED_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // hold the beat until taken, otherwise offer the next one or idle
    always @(negedge i_clk) begin
        t_chassis_cmd nxt;
        if (!i_rst_n) begin
            cmd_bus.valid          <= 1'b0;
            cmd_bus.speed_sideways <= '0;
            cmd_bus.speed_forward  <= '0;
            cmd_bus.speed_rotate   <= '0;
            whl_bus.ready          <= 1'b0;
        end else begin
            if (!(cmd_bus.valid && !cmd_taken)) begin
                if (cmd_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = cmd_pending.pop_front();
                    cmd_bus.valid          <= 1'b1;
                    cmd_bus.speed_sideways <= nxt.sideways;
                    cmd_bus.speed_forward  <= nxt.forward;
                    cmd_bus.speed_rotate   <= nxt.rotate;
                end else begin
                    cmd_bus.valid <= 1'b0;
                end
            end
            whl_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_chassis_cmd c;
        t_wheel_set   got;
        t_wheel_set   want;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                c.sideways = cmd_bus.speed_sideways;
                c.forward  = cmd_bus.speed_forward;
                c.rotate   = cmd_bus.speed_rotate;
                wheel_expect.push_back(mix_and_desaturate(c, limit_model));
                cmd_accepted++;
                moved = 1'b1;
            end
            if (whl_bus.valid && whl_bus.ready) begin
                moved = 1'b1;
                got.front_a = whl_bus.wheel_front_a;
                got.front_b = whl_bus.wheel_front_b;
                got.rear_a  = whl_bus.wheel_rear_a;
                got.rear_b  = whl_bus.wheel_rear_b;
                got.scaled  = whl_bus.was_scaled;
                if (wheel_expect.size() == 0) begin
                    report_mismatch("unexpected beat, front_a", got.front_a, 0);
                end else begin
                    want = wheel_expect.pop_front();
                    wheels_checked++;
                    if (want.scaled) scaled_seen++;
                    if (got.front_a !== want.front_a)
                        report_mismatch("wheel_front_a", got.front_a, want.front_a);
                    if (got.front_b !== want.front_b)
                        report_mismatch("wheel_front_b", got.front_b, want.front_b);
                    if (got.rear_a !== want.rear_a)
                        report_mismatch("wheel_rear_a", got.rear_a, want.rear_a);
                    if (got.rear_b !== want.rear_b)
                        report_mismatch("wheel_rear_b", got.rear_b, want.rear_b);
                    if (got.scaled !== want.scaled)
                        report_mismatch("was_scaled", got.scaled, want.scaled);
                end
            end
            if (i_cfg_wr_en) limit_model = i_cfg_wr_data;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        cmd_taken = i_rst_n && cmd_bus.valid && cmd_bus.ready;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic queue_cmd(int sx, int fy, int rz);
        t_chassis_cmd c;
        c.sideways = sx[SPEED_W-1:0];
        c.forward  = fy[SPEED_W-1:0];
        c.rotate   = rz[SPEED_W-1:0];
        cmd_pending.push_back(c);
        cmd_queued++;
    endtask

    function automatic int pick_extreme();
        int vals[6] = '{-32768, -32767, -1, 0, 1, 32767};
        return vals[$urandom_range(0, 5)];
    endfunction

    task automatic queue_random(int n);
        int lim;
        int s;
        int kind;
        int v;
        int f[3];
        lim = limit_model;
        s = lim / 3 + 1;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            for (int j = 0; j < 3; j++) begin
                if (kind < 4) f[j] = int'($urandom_range(0, 65535)) - 32768;
                else if (kind < 6) f[j] = int'($urandom_range(0, 2 * s)) - s;
                else if (kind < 8) f[j] = pick_extreme();
                else f[j] = 0;
            end
            // land the peak right at the limit or one past it
            if (kind >= 8) begin
                v = lim + ((lim < 32767) ? int'($urandom_range(0, 1)) : 0);
                f[$urandom_range(0, 2)] = $urandom_range(0, 1) ? v : -v;
            end
            queue_cmd(f[0], f[1], f[2]);
        end
    endtask

    task automatic drain();
        while (cmd_accepted != cmd_queued || wheel_expect.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIM_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_idle(t_idle_mode mode);
        send_idle_pct  = (mode == IDLE_SENDER)   ? 64 : (mode == IDLE_BOTH) ? 7 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 64 : (mode == IDLE_BOTH) ? 7 : 0;
    endtask

    initial begin
        logic [LIM_W-1:0] limits[6];
        i_rst_n               = 1'b0;
        i_cfg_wr_en           = 1'b0;
        i_cfg_wr_data         = '0;
        limit_model    = LIMIT_RESET;
        cmd_queued     = 0;
        cmd_accepted   = 0;
        wheels_checked = 0;
        scaled_seen    = 0;
        limit_writes   = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        cmd_taken      = 1'b0;
        set_idle(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit: field extremes and sums that need 18 bits
        queue_cmd(0, 0, 0);
        queue_cmd(32767, 0, 0);
        queue_cmd(-32768, 0, 0);
        queue_cmd(0, 32767, 0);
        queue_cmd(0, -32768, 0);
        queue_cmd(0, 0, 32767);
        queue_cmd(0, 0, -32768);
        queue_cmd(32767, 32767, 32767);
        queue_cmd(-32768, -32768, -32768);
        queue_cmd(-32768, 32767, -32768);
        queue_cmd(32767, -32768, 32767);
        queue_cmd(1, -1, 1);
        queue_random(PHASE_ITEMS);

        // zero limit: every nonzero mix collapses to zero
        write_limit('0);
        set_idle(IDLE_SENDER);
        queue_cmd(0, 0, 0);
        queue_cmd(1, 0, 0);
        queue_cmd(-5, 3, 7);
        queue_random(PHASE_ITEMS);

        // peak equal to the limit passes, one above scales
        write_limit(LIM_W'(1000));
        set_idle(IDLE_RECEIVER);
        queue_cmd(1000, 0, 0);
        queue_cmd(0, 0, 1001);
        queue_cmd(0, 500, 500);
        queue_cmd(-1000, 0, 0);
        queue_cmd(0, -501, 500);
        queue_random(PHASE_ITEMS);

        write_limit(LIMIT_RESET);
        set_idle(IDLE_BOTH);
        queue_random(PHASE_ITEMS);

        limits = '{LIM_W'(1), LIM_W'(32766), LIM_W'(16384),
                   LIM_W'($urandom), LIM_W'($urandom), LIM_W'($urandom)};
        for (int p = 0; p < 6; p++) begin
            write_limit(limits[p]);
            set_idle(t_idle_mode'(p % 4));
            queue_random(PHASE_ITEMS);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d chassis commands over %0d limit settings and four idle patterns",
                 cmd_accepted, limit_writes + 1);
        $display("Checked %0d wheel beats, %0d of them desaturated, %0d mismatches",
                 wheels_checked, scaled_seen, mismatches);
        if (mismatches == 0 && wheel_expect.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mwm_pkg.sv
rtl/core/mwm_cmd_if.sv
rtl/core/mwm_whl_if.sv
rtl/core/mwm_mix.sv
rtl/core/mwm_div_cell.sv
rtl/core/mecanum_wheel_mixer.sv
tb/mecanum_wheel_mixer_tb.sv
